FILE: design/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Default geometry of the usage map.
	localparam int NUM_BLOCKS_DEF  = 1024;
	localparam int MAX_REQUEST_DEF = 64;

	// The map is held as rows of WORD_W usage bits.
	localparam int WORD_W = 32;
	localparam int BIT_W  = $clog2(WORD_W);

	// Width of the request count field.
	localparam int REQ_W = 7;

	// Operation codes of the func field.
	localparam logic FUNC_TAKE = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_TAKE_RD,
		ST_TAKE_SCAN,
		ST_TAKE_WR,
		ST_EMIT
	} bba_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic mem_clear;
		logic load_work;
		logic free_apply;
		logic grant;
		logic write_back;
		logic row_inc;
		logic emit_status;
	} bba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_func;
		logic take_none;
		logic batch_end;
		logic rem_zero;
		logic word_has_free;
		logic slot_free;
		logic last_row;
	} bba_status_t;

endpackage

FILE: design/bba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Request channel (take or free items) and response channel (grant results),
// each a valid/ready handshake with its payload fields.
// ----------------------------------------------------------------------------
interface bba_req_if #(
	parameter int BLK_W = 10
);
	logic             valid;
	logic             ready;
	logic             func;
	logic [6:0]       request_count;
	logic [BLK_W-1:0] free_index;
	logic             batch_end;

	modport source (
		output valid, func, request_count, free_index, batch_end,
		input  ready
	);

	modport sink (
		input  valid, func, request_count, free_index, batch_end,
		output ready
	);
endinterface

interface bba_rsp_if #(
	parameter int BLK_W = 10,
	parameter int CNT_W = 11
);
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] block_number;
	logic             granted;
	logic             last;
	logic [CNT_W-1:0] used_count;

	modport source (
		output valid, block_number, granted, last, used_count,
		input  ready
	);

	modport sink (
		input  valid, block_number, granted, last, used_count,
		output ready
	);
endinterface

FILE: design/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// State machine that sequences the clearing pass, free items and the
// row-by-row first-fit scan of take requests.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bba_pkg::bba_status_t status,
	output bba_pkg::bba_cmd_t    cmd
);
	import bba_pkg::*;

	bba_state_t state_q;
	bba_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.last_row) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (status.in_valid) begin
					if (status.in_func == FUNC_FREE) begin
						state_next = ST_FREE_RD;
					end else if (status.take_none) begin
						state_next = ST_EMIT;
					end else begin
						state_next = ST_TAKE_RD;
					end
				end
			end
			ST_FREE_RD: begin
				state_next = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				state_next = status.batch_end ? ST_EMIT : ST_IDLE;
			end
			ST_TAKE_RD: begin
				state_next = ST_TAKE_SCAN;
			end
			ST_TAKE_SCAN: begin
				if (status.rem_zero || !status.word_has_free) begin
					state_next = ST_TAKE_WR;
				end
			end
			ST_TAKE_WR: begin
				state_next = status.rem_zero ? ST_IDLE : ST_TAKE_RD;
			end
			ST_EMIT: begin
				if (status.slot_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.mem_clear = 1'b1;
				cmd.row_inc   = 1'b1;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ST_FREE_RD: begin
				cmd.load_work = 1'b1;
			end
			ST_FREE_WR: begin
				cmd.free_apply = 1'b1;
			end
			ST_TAKE_RD: begin
				cmd.load_work = 1'b1;
			end
			ST_TAKE_SCAN: begin
				cmd.grant = !status.rem_zero && status.word_has_free && status.slot_free;
			end
			ST_TAKE_WR: begin
				cmd.write_back = 1'b1;
				cmd.row_inc    = !status.rem_zero;
			end
			ST_EMIT: begin
				cmd.emit_status = status.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/bba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Usage map memory, working row, request and used counters, and the
// registered response stage.
// ----------------------------------------------------------------------------
module bba_datapath #(
	parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bba_pkg::bba_cmd_t    cmd,
	output bba_pkg::bba_status_t status,
	bba_req_if.sink              req,
	bba_rsp_if.source            rsp
);
	import bba_pkg::*;

	localparam int BLK_W    = $clog2(NUM_BLOCKS);
	localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
	localparam int NUM_ROWS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int ADDR_W   = ROW_W + BIT_W;
	localparam int REM_W    = $clog2(MAX_REQUEST + 1);
	localparam int CMP_W    = (CNT_W > REQ_W) ? CNT_W : REQ_W;

	logic [WORD_W-1:0] mem [NUM_ROWS];

	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] work_q;
	logic [REM_W-1:0]  remaining_q;
	logic [CNT_W-1:0]  used_q;
	logic [BIT_W-1:0]  free_bit_q;
	logic              free_in_range_q;
	logic              batch_end_q;

	logic              out_valid_q;
	logic [BLK_W-1:0]  out_block_q;
	logic              out_granted_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_used_q;

	logic              accept;
	logic [REQ_W-1:0]  want;
	logic [CNT_W-1:0]  free_cnt;
	logic [CMP_W-1:0]  grant_n;
	logic [ADDR_W-1:0] free_addr;
	logic              free_in_range;
	logic [BIT_W-1:0]  zero_pos;
	logic [ADDR_W-1:0] grant_addr;
	logic              free_hit;
	logic              mem_wr_en;
	logic [WORD_W-1:0] mem_wr_data;
	logic              slot_free;

	assign accept    = cmd.in_ready && req.valid;
	assign req.ready = cmd.in_ready;

	// Request size: saturate, then limit to the blocks still free.
	assign want     = (req.request_count > REQ_W'(MAX_REQUEST)) ?
		REQ_W'(MAX_REQUEST) : req.request_count;
	assign free_cnt = CNT_W'(NUM_BLOCKS) - used_q;
	assign grant_n  = (CMP_W'(want) < CMP_W'(free_cnt)) ? CMP_W'(want) : CMP_W'(free_cnt);

	// Row and bit of the block named by a free item.
	assign free_addr     = ADDR_W'(req.free_index);
	assign free_in_range = (ADDR_W'(req.free_index) < ADDR_W'(NUM_BLOCKS)) ||
		((ADDR_W + 1)'(req.free_index) < (ADDR_W + 1)'(NUM_BLOCKS) && ADDR_W < BLK_W + 1);

	// Lowest free bit of the working row.
	always_comb begin
		zero_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!work_q[i]) begin
				zero_pos = BIT_W'(i);
			end
		end
	end

	assign grant_addr = {row_q, zero_pos};
	assign free_hit   = free_in_range_q && work_q[free_bit_q];
	assign slot_free  = !out_valid_q || rsp.ready;

	// Usage map write port.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_data = work_q;
		if (cmd.mem_clear) begin
			mem_wr_en   = 1'b1;
			mem_wr_data = '0;
		end else if (cmd.free_apply) begin
			mem_wr_en   = free_hit;
			mem_wr_data = work_q & ~(WORD_W'(1) << free_bit_q);
		end else if (cmd.write_back) begin
			mem_wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			mem[row_q] <= mem_wr_data;
		end
	end

	// Working row: registered read of the map, then one bit set per grant.
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			work_q <= mem[row_q];
		end else if (cmd.grant) begin
			work_q[zero_pos] <= 1'b1;
		end
	end

	// Row pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (accept) begin
			row_q <= (req.func == FUNC_FREE && free_in_range) ?
				free_addr[ADDR_W-1:BIT_W] : '0;
		end else if (cmd.row_inc) begin
			row_q <= (row_q == ROW_W'(NUM_ROWS - 1)) ? '0 : ROW_W'(row_q + 1'b1);
		end
	end

	// Used count and remaining grants.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			remaining_q <= '0;
		end else begin
			if (accept && req.func == FUNC_TAKE) begin
				used_q      <= used_q + CNT_W'(grant_n);
				remaining_q <= REM_W'(grant_n);
			end else if (cmd.free_apply && free_hit) begin
				used_q <= used_q - 1'b1;
			end else if (cmd.grant) begin
				remaining_q <= remaining_q - 1'b1;
			end
		end
	end

	// Free item fields held for the read-modify-write.
	always_ff @(posedge clk) begin
		if (accept) begin
			free_bit_q      <= free_addr[BIT_W-1:0];
			free_in_range_q <= free_in_range;
			batch_end_q     <= req.batch_end;
		end
	end

	// Response register; a new result loads when the slot is empty or leaving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.grant || cmd.emit_status) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grant) begin
			out_block_q   <= grant_addr[BLK_W-1:0];
			out_granted_q <= 1'b1;
			out_last_q    <= (remaining_q == REM_W'(1));
			out_used_q    <= used_q;
		end else if (cmd.emit_status) begin
			out_block_q   <= '0;
			out_granted_q <= 1'b0;
			out_last_q    <= 1'b1;
			out_used_q    <= used_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.block_number = out_block_q;
	assign rsp.granted      = out_granted_q;
	assign rsp.last         = out_last_q;
	assign rsp.used_count   = out_used_q;

	// Status toward the controller.
	always_comb begin
		status               = '0;
		status.in_valid      = req.valid;
		status.in_func       = req.func;
		status.take_none     = (grant_n == '0);
		status.batch_end     = batch_end_q;
		status.rem_zero      = (remaining_q == '0);
		status.word_has_free = !(&work_q);
		status.slot_free     = slot_free;
		status.last_row      = (row_q == ROW_W'(NUM_ROWS - 1));
	end

endmodule

FILE: design/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block usage map with a used count.
//
//   Channel  Dir  Payload
//   req      in   func, request_count, free_index, batch_end
//   rsp      out  block_number, granted, last, used_count
//
// After reset a clearing pass writes the map, one 32-bit row per cycle, during
// which req is not ready. A free item is accepted, its map row is read and
// written back; a status result follows when it ends a batch. Each row a take
// request visits is read, scanned granting one block per cycle and written
// back; a take that grants nothing emits only a status result.
// Results wait in an output register; a full register stalls the scan.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	bba_cmd_t    cmd;
	bba_status_t status;

	// Sequencer.
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Map, counters and response stage.
	bba_datapath #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.MAX_REQUEST (MAX_REQUEST)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
